FILE: hdl/ppcs_pkg.sv
// Shared types, operation codes and limits for the preemptive priority cue scheduler.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package ppcs_pkg;

   localparam logic [1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [19:0]        MAX_DURATION_MS = 20'd300000;
   localparam logic signed [15:0] PRIO_HI_REQ     = 16'sd1000;
   localparam logic signed [15:0] PRIO_LO_REQ     = -16'sd1000;
   localparam logic signed [10:0] PRIO_HI         = 11'sd1000;
   localparam logic signed [10:0] PRIO_LO         = -11'sd1000;

   typedef struct packed {
      logic [15:0]        key;
      logic [31:0]        text;
      logic [31:0]        spk;
      logic signed [10:0] prio;
      logic [18:0]        dur;
      logic [31:0]        seq;
   } entry_type;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_DEC   = 11'b000_0000_0010,
      S_SRCH  = 11'b000_0000_0100,
      S_NEWC  = 11'b000_0000_1000,
      S_REM   = 11'b000_0001_0000,
      S_INSST = 11'b000_0010_0000,
      S_INS   = 11'b000_0100_0000,
      S_INSW  = 11'b000_1000_0000,
      S_TICK  = 11'b001_0000_0000,
      S_PROMO = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   function automatic logic goes_first(input logic signed [10:0] pa, input logic [31:0] sa,
                                       input logic signed [10:0] pb, input logic [31:0] sb);
      logic r;
      if (pa != pb) r = (pa > pb);
      else r = (sa < sb);
      return r;
   endfunction

endpackage

FILE: hdl/preemptive_priority_cue_scheduler.sv
// Top level of the preemptive priority cue scheduler: one active cue plus a sorted wait queue.
// The queue lives in a synchronous memory; a sequencer reads, shifts and writes it back.
// Depends on ppcs_pkg.
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | op, cue id, handles, priority, duration, delta
// rsp     | out       | rsp_valid/rsp_stall  | accepted, shown cue, queued and dropped counts
//
// An enqueue works through key search, slot removal and backward insertion, one memory
// entry per cycle. A tick that expires cues promotes the queue head and shifts the rest up.
// The result waits in the last state while rsp_stall holds it off.
// Reset is synchronous and clears the active cue and all counters; the queue memory is
// not cleared. A stalled result sits in the output register while the next item is taken.

module preemptive_priority_cue_scheduler #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_op,
   input  logic [15:0]                           req_cue_id,
   input  logic [31:0]                           req_text_handle,
   input  logic [31:0]                           req_speaker_handle,
   input  logic signed [15:0]                    req_priority_req,
   input  logic [19:0]                           req_duration_ms,
   input  logic [19:0]                           req_delta_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_accepted,
   output logic                                  rsp_visible,
   output logic [15:0]                           rsp_shown_id,
   output logic [31:0]                           rsp_shown_text,
   output logic [31:0]                           rsp_shown_speaker,
   output logic [18:0]                           rsp_remaining_ms,
   output logic signed [10:0]                    rsp_shown_priority,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      rsp_queued_count,
   output logic [31:0]                           rsp_dropped_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   ppcs_pkg::entry_type queue_ff [QUEUE_DEPTH+1];
   ppcs_pkg::entry_type rd_data_ff;
   logic                mem_we;
   logic [CW-1:0]       mem_wa;
   logic [CW-1:0]       mem_ra;
   ppcs_pkg::entry_type mem_wd;

   ppcs_pkg::state_type state_ff, state_in;

   logic [1:0]         op_ff, op_in;
   logic [15:0]        key_ff, key_in;
   logic [31:0]        text_ff, text_in;
   logic [31:0]        spk_ff, spk_in;
   logic signed [10:0] prio_ff, prio_in;
   logic [19:0]        dur_ff, dur_in;
   logic [19:0]        delta_ff, delta_in;
   logic               ok_ff, ok_in;

   logic               act_valid_ff, act_valid_in;
   logic [15:0]        act_key_ff, act_key_in;
   logic [31:0]        act_text_ff, act_text_in;
   logic [31:0]        act_spk_ff, act_spk_in;
   logic signed [10:0] act_prio_ff, act_prio_in;
   logic [31:0]        act_seq_ff, act_seq_in;
   logic [18:0]        time_left_ff, time_left_in;

   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        next_seq_ff, next_seq_in;
   logic [31:0]        drop_ff, drop_in;
   ppcs_pkg::entry_type ins_ff, ins_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               rem_tick_ff, rem_tick_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_accepted_ff, rsp_accepted_in;
   logic               rsp_visible_ff, rsp_visible_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic [31:0]        rsp_text_ff, rsp_text_in;
   logic [31:0]        rsp_spk_ff, rsp_spk_in;
   logic [18:0]        rsp_rem_ff, rsp_rem_in;
   logic signed [10:0] rsp_prio_ff, rsp_prio_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic [31:0]        rsp_drop_ff, rsp_drop_in;

   logic [CW:0]        idx_p1;
   logic [CW:0]        idx_p2;
   logic [CW:0]        cnt_inc;
   logic               trim;
   logic [CW-1:0]      count_ins;
   logic [31:0]        drop_ins;
   logic               dur_ok;
   logic               rd_first;
   logic [19:0]        time_left_20;
   ppcs_pkg::entry_type new_entry;

   always_ff @(posedge clock) begin
      if (mem_we) queue_ff[mem_wa] <= mem_wd;
      rd_data_ff <= queue_ff[mem_ra];
   end

   assign idx_p1    = {1'b0, idx_ff} + (CW+1)'(1);
   assign idx_p2    = {1'b0, idx_ff} + (CW+1)'(2);
   assign cnt_inc   = {1'b0, count_ff} + (CW+1)'(1);
   assign trim      = cnt_inc > (CW+1)'(QUEUE_DEPTH);
   assign count_ins = trim ? CW'(QUEUE_DEPTH) : cnt_inc[CW-1:0];
   assign drop_ins  = (trim && (drop_ff != '1)) ? drop_ff + 32'd1 : drop_ff;
   assign dur_ok    = (dur_ff != 20'd0) && (dur_ff <= ppcs_pkg::MAX_DURATION_MS);
   assign rd_first  = ppcs_pkg::goes_first(ins_ff.prio, ins_ff.seq,
                                           rd_data_ff.prio, rd_data_ff.seq);
   assign time_left_20 = {1'b0, time_left_ff};

   always_comb begin
      new_entry.key  = key_ff;
      new_entry.text = text_ff;
      new_entry.spk  = spk_ff;
      new_entry.prio = prio_ff;
      new_entry.dur  = dur_ff[18:0];
      new_entry.seq  = next_seq_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      text_in      = text_ff;
      spk_in       = spk_ff;
      prio_in      = prio_ff;
      dur_in       = dur_ff;
      delta_in     = delta_ff;
      ok_in        = ok_ff;
      act_valid_in = act_valid_ff;
      act_key_in   = act_key_ff;
      act_text_in  = act_text_ff;
      act_spk_in   = act_spk_ff;
      act_prio_in  = act_prio_ff;
      act_seq_in   = act_seq_ff;
      time_left_in = time_left_ff;
      count_in     = count_ff;
      next_seq_in  = next_seq_ff;
      drop_in      = drop_ff;
      ins_in       = ins_ff;
      idx_in       = idx_ff;
      rem_tick_in  = rem_tick_ff;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = ins_ff;
      mem_ra       = '0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_visible_in  = rsp_visible_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_text_in     = rsp_text_ff;
      rsp_spk_in      = rsp_spk_ff;
      rsp_rem_in      = rsp_rem_ff;
      rsp_prio_in     = rsp_prio_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_drop_in     = rsp_drop_ff;

      unique case (state_ff)
         ppcs_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = req_cue_id;
               text_in  = req_text_handle;
               spk_in   = req_speaker_handle;
               dur_in   = req_duration_ms;
               delta_in = req_delta_ms;
               if (req_priority_req > ppcs_pkg::PRIO_HI_REQ) prio_in = ppcs_pkg::PRIO_HI;
               else if (req_priority_req < ppcs_pkg::PRIO_LO_REQ) prio_in = ppcs_pkg::PRIO_LO;
               else prio_in = req_priority_req[10:0];
               state_in = ppcs_pkg::S_DEC;
            end
         end
         ppcs_pkg::S_DEC: begin
            unique case (op_ff)
               ppcs_pkg::OP_ENQUEUE: begin
                  if (key_ff == 16'd0 || text_ff == 32'd0 || !dur_ok) begin
                     ok_in    = 1'b0;
                     state_in = ppcs_pkg::S_DONE;
                  end else begin
                     ok_in = 1'b1;
                     if (act_valid_ff && act_key_ff == key_ff) begin
                        act_text_in  = text_ff;
                        act_spk_in   = spk_ff;
                        act_prio_in  = prio_ff;
                        time_left_in = dur_ff[18:0];
                        state_in     = ppcs_pkg::S_DONE;
                     end else if (count_ff != '0) begin
                        mem_ra   = '0;
                        idx_in   = '0;
                        state_in = ppcs_pkg::S_SRCH;
                     end else begin
                        state_in = ppcs_pkg::S_NEWC;
                     end
                  end
               end
               ppcs_pkg::OP_TICK: begin
                  ok_in    = 1'b1;
                  state_in = ppcs_pkg::S_TICK;
               end
               ppcs_pkg::OP_CLEAR: begin
                  ok_in        = 1'b1;
                  count_in     = '0;
                  act_valid_in = 1'b0;
                  time_left_in = '0;
                  state_in     = ppcs_pkg::S_DONE;
               end
               default: begin
                  ok_in    = 1'b0;
                  state_in = ppcs_pkg::S_DONE;
               end
            endcase
         end
         ppcs_pkg::S_SRCH: begin
            if (rd_data_ff.key == key_ff) begin
               ins_in     = new_entry;
               ins_in.seq = rd_data_ff.seq;
               if (idx_p1 < {1'b0, count_ff}) begin
                  mem_ra      = idx_p1[CW-1:0];
                  rem_tick_in = 1'b0;
                  state_in    = ppcs_pkg::S_REM;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = ppcs_pkg::S_INSST;
               end
            end else if (idx_p1 < {1'b0, count_ff}) begin
               mem_ra = idx_p1[CW-1:0];
               idx_in = idx_p1[CW-1:0];
            end else begin
               state_in = ppcs_pkg::S_NEWC;
            end
         end
         ppcs_pkg::S_NEWC: begin
            next_seq_in = next_seq_ff + 32'd1;
            if (act_valid_ff && prio_ff > act_prio_ff) begin
               ins_in.key  = act_key_ff;
               ins_in.text = act_text_ff;
               ins_in.spk  = act_spk_ff;
               ins_in.prio = act_prio_ff;
               ins_in.dur  = time_left_ff;
               ins_in.seq  = act_seq_ff;
               act_key_in   = key_ff;
               act_text_in  = text_ff;
               act_spk_in   = spk_ff;
               act_prio_in  = prio_ff;
               act_seq_in   = next_seq_ff;
               time_left_in = dur_ff[18:0];
               state_in     = ppcs_pkg::S_INSST;
            end else if (!act_valid_ff) begin
               act_valid_in = 1'b1;
               act_key_in   = key_ff;
               act_text_in  = text_ff;
               act_spk_in   = spk_ff;
               act_prio_in  = prio_ff;
               act_seq_in   = next_seq_ff;
               time_left_in = dur_ff[18:0];
               state_in     = ppcs_pkg::S_DONE;
            end else begin
               ins_in   = new_entry;
               state_in = ppcs_pkg::S_INSST;
            end
         end
         ppcs_pkg::S_REM: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = rd_data_ff;
            if (idx_p2 < {1'b0, count_ff}) begin
               mem_ra = idx_p2[CW-1:0];
               idx_in = idx_p1[CW-1:0];
            end else begin
               count_in = count_ff - CW'(1);
               state_in = rem_tick_ff ? ppcs_pkg::S_TICK : ppcs_pkg::S_INSST;
            end
         end
         ppcs_pkg::S_INSST: begin
            if (count_ff == '0) begin
               mem_we   = 1'b1;
               mem_wa   = '0;
               count_in = count_ins;
               drop_in  = drop_ins;
               state_in = ppcs_pkg::S_DONE;
            end else begin
               mem_ra   = count_ff - CW'(1);
               idx_in   = count_ff - CW'(1);
               state_in = ppcs_pkg::S_INS;
            end
         end
         ppcs_pkg::S_INS: begin
            mem_we = 1'b1;
            mem_wa = idx_p1[CW-1:0];
            if (rd_first) begin
               mem_wd = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ppcs_pkg::S_INSW;
               end else begin
                  mem_ra = idx_ff - CW'(1);
                  idx_in = idx_ff - CW'(1);
               end
            end else begin
               count_in = count_ins;
               drop_in  = drop_ins;
               state_in = ppcs_pkg::S_DONE;
            end
         end
         ppcs_pkg::S_INSW: begin
            mem_we   = 1'b1;
            mem_wa   = '0;
            count_in = count_ins;
            drop_in  = drop_ins;
            state_in = ppcs_pkg::S_DONE;
         end
         ppcs_pkg::S_TICK: begin
            if (!act_valid_ff || delta_ff == 20'd0) begin
               state_in = ppcs_pkg::S_DONE;
            end else if (delta_ff < time_left_20) begin
               time_left_in = time_left_ff - delta_ff[18:0];
               delta_in     = '0;
               state_in     = ppcs_pkg::S_DONE;
            end else begin
               delta_in     = delta_ff - time_left_20;
               act_valid_in = 1'b0;
               time_left_in = '0;
               if (count_ff != '0) begin
                  mem_ra   = '0;
                  state_in = ppcs_pkg::S_PROMO;
               end else begin
                  state_in = ppcs_pkg::S_DONE;
               end
            end
         end
         ppcs_pkg::S_PROMO: begin
            act_valid_in = 1'b1;
            act_key_in   = rd_data_ff.key;
            act_text_in  = rd_data_ff.text;
            act_spk_in   = rd_data_ff.spk;
            act_prio_in  = rd_data_ff.prio;
            act_seq_in   = rd_data_ff.seq;
            time_left_in = rd_data_ff.dur;
            if (count_ff > CW'(1)) begin
               mem_ra      = CW'(1);
               idx_in      = '0;
               rem_tick_in = 1'b1;
               state_in    = ppcs_pkg::S_REM;
            end else begin
               count_in = '0;
               state_in = ppcs_pkg::S_TICK;
            end
         end
         ppcs_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = ok_ff;
               rsp_visible_in  = act_valid_ff;
               rsp_id_in       = act_valid_ff ? act_key_ff : '0;
               rsp_text_in     = act_valid_ff ? act_text_ff : '0;
               rsp_spk_in      = act_valid_ff ? act_spk_ff : '0;
               rsp_rem_in      = act_valid_ff ? time_left_ff : '0;
               rsp_prio_in     = act_valid_ff ? act_prio_ff : '0;
               rsp_count_in    = count_ff;
               rsp_drop_in     = drop_ff;
               state_in        = ppcs_pkg::S_IDLE;
            end
         end
         default: state_in = ppcs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppcs_pkg::S_IDLE;
         act_valid_ff <= 1'b0;
         act_key_ff   <= '0;
         act_text_ff  <= '0;
         act_spk_ff   <= '0;
         act_prio_ff  <= '0;
         act_seq_ff   <= '0;
         time_left_ff <= '0;
         count_ff     <= '0;
         next_seq_ff  <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_valid_ff <= act_valid_in;
         act_key_ff   <= act_key_in;
         act_text_ff  <= act_text_in;
         act_spk_ff   <= act_spk_in;
         act_prio_ff  <= act_prio_in;
         act_seq_ff   <= act_seq_in;
         time_left_ff <= time_left_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      key_ff          <= key_in;
      text_ff         <= text_in;
      spk_ff          <= spk_in;
      prio_ff         <= prio_in;
      dur_ff          <= dur_in;
      delta_ff        <= delta_in;
      ok_ff           <= ok_in;
      ins_ff          <= ins_in;
      idx_ff          <= idx_in;
      rem_tick_ff     <= rem_tick_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_visible_ff  <= rsp_visible_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_text_ff     <= rsp_text_in;
      rsp_spk_ff      <= rsp_spk_in;
      rsp_rem_ff      <= rsp_rem_in;
      rsp_prio_ff     <= rsp_prio_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_drop_ff     <= rsp_drop_in;
   end

   assign req_stall          = (state_ff != ppcs_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_visible        = rsp_visible_ff;
   assign rsp_shown_id       = rsp_id_ff;
   assign rsp_shown_text     = rsp_text_ff;
   assign rsp_shown_speaker  = rsp_spk_ff;
   assign rsp_remaining_ms   = rsp_rem_ff;
   assign rsp_shown_priority = rsp_prio_ff;
   assign rsp_queued_count   = rsp_count_ff;
   assign rsp_dropped_count  = rsp_drop_ff;

endmodule

FILE: hdl/ppcs_checker.sv
// Port-level checks for the preemptive priority cue scheduler, bound to the top level.
// Depends on ppcs_pkg and preemptive_priority_cue_scheduler.
`timescale 1ns / 1ps

module ppcs_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_visible,
   input logic [15:0]                      rsp_shown_id,
   input logic [18:0]                      rsp_remaining_ms,
   input logic signed [10:0]               rsp_shown_priority,
   input logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_queued_count
);

   a_hidden_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_shown_id == 16'd0 && rsp_remaining_ms == 19'd0)
      else $error("hidden cue shows nonzero fields");

   a_visible_has_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_visible |-> rsp_remaining_ms != 19'd0 && rsp_shown_id != 16'd0)
      else $error("visible cue without time or id");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_shown_priority <= ppcs_pkg::PRIO_HI
                 && rsp_shown_priority >= ppcs_pkg::PRIO_LO)
      else $error("shown priority out of range");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_queued_count} <= ($clog2(QUEUE_DEPTH+1)+1)'(QUEUE_DEPTH))
      else $error("queued count above depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shown_id))
      else $error("stalled transfer changed");

endmodule

bind preemptive_priority_cue_scheduler ppcs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ppcs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_visible        (rsp_visible),
   .rsp_shown_id       (rsp_shown_id),
   .rsp_remaining_ms   (rsp_remaining_ms),
   .rsp_shown_priority (rsp_shown_priority),
   .rsp_queued_count   (rsp_queued_count)
);

FILE: verif/tb_preemptive_priority_cue_scheduler.sv
// Testbench for the preemptive priority cue scheduler: random and directed cue traffic
// checked against a scoreboard class holding its own model of the active cue and queue.
// Depends on ppcs_pkg and preemptive_priority_cue_scheduler.
`timescale 1ns / 1ps

typedef struct {
   logic [1:0]         op;
   logic [15:0]        cue_id;
   logic [31:0]        text;
   logic [31:0]        spk;
   logic signed [15:0] prio;
   logic [19:0]        dur;
   logic [19:0]        delta;
} cue_req_type;

typedef struct packed {
   logic               accepted;
   logic               visible;
   logic [15:0]        shown_id;
   logic [31:0]        shown_text;
   logic [31:0]        shown_speaker;
   logic [18:0]        remaining_ms;
   logic signed [10:0] shown_priority;
   logic [4:0]         queued_count;
   logic [31:0]        dropped_count;
} cue_view_type;

class cue_scoreboard;
   localparam int DEPTH = 16;
   bit                 act_on;
   ppcs_pkg::entry_type act;
   ppcs_pkg::entry_type waitq[$];
   logic [31:0]        seq_next;
   logic [31:0]        drops;
   cue_view_type       pending[$];
   int                 errors;

   function new();
      act_on = 0;
      act = '0;
      seq_next = 0;
      drops = 0;
      errors = 0;
   endfunction

   function bit ahead(ppcs_pkg::entry_type a, ppcs_pkg::entry_type b);
      if (a.prio != b.prio) return a.prio > b.prio;
      return a.seq < b.seq;
   endfunction

   function void place(ppcs_pkg::entry_type e);
      int pos;
      pos = 0;
      while (pos < waitq.size() && !ahead(e, waitq[pos])) pos++;
      waitq.insert(pos, e);
   endfunction

   function bit enqueue(cue_req_type r);
      ppcs_pkg::entry_type e;
      int p;
      if (r.cue_id == 0 || r.text == 0 || r.dur == 0 || r.dur > 300000) return 0;
      p = r.prio;
      if (p > 1000) p = 1000;
      if (p < -1000) p = -1000;
      e.key = r.cue_id;
      e.text = r.text;
      e.spk = r.spk;
      e.prio = 11'(p);
      e.dur = r.dur[18:0];
      if (act_on && act.key == r.cue_id) begin
         e.seq = act.seq;
         act = e;
         return 1;
      end
      foreach (waitq[i]) begin
         if (waitq[i].key == r.cue_id) begin
            e.seq = waitq[i].seq;
            waitq.delete(i);
            place(e);
            return 1;
         end
      end
      e.seq = seq_next;
      seq_next++;
      if (act_on && e.prio > act.prio) begin
         place(act);
         act = e;
      end else if (!act_on) begin
         act_on = 1;
         act = e;
      end else place(e);
      if (waitq.size() > DEPTH) begin
         waitq.delete(waitq.size() - 1);
         if (drops != 32'hFFFF_FFFF) drops++;
      end
      return 1;
   endfunction

   function void tick(logic [19:0] d);
      int unsigned delta;
      delta = d;
      while (act_on && delta > 0) begin
         if (delta < act.dur) begin
            act.dur = act.dur - 19'(delta);
            delta = 0;
         end else begin
            delta -= act.dur;
            act_on = 0;
            if (waitq.size() > 0) begin
               act = waitq.pop_front();
               act_on = 1;
            end
         end
      end
   endfunction

   function void note_request(cue_req_type r);
      cue_view_type v;
      case (r.op)
         ppcs_pkg::OP_ENQUEUE: v.accepted = enqueue(r);
         ppcs_pkg::OP_TICK: begin
            tick(r.delta);
            v.accepted = 1;
         end
         ppcs_pkg::OP_CLEAR: begin
            waitq.delete();
            act_on = 0;
            v.accepted = 1;
         end
         default: v.accepted = 0;
      endcase
      v.visible = act_on;
      v.shown_id = act_on ? act.key : '0;
      v.shown_text = act_on ? act.text : '0;
      v.shown_speaker = act_on ? act.spk : '0;
      v.remaining_ms = act_on ? act.dur : '0;
      v.shown_priority = act_on ? act.prio : '0;
      v.queued_count = 5'(waitq.size());
      v.dropped_count = drops;
      pending.insert(pending.size(), v);
   endfunction

   function void check_result(cue_view_type got);
      cue_view_type x;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result id %0h", $time, got.shown_id);
         errors++;
         return;
      end
      x = pending.pop_front();
      if (got !== x) begin
         $display("%0t: mismatch expected acc %0d vis %0d id %0h txt %0h spk %0h rem %0d pri %0d q %0d drop %0d",
                  $time, x.accepted, x.visible, x.shown_id, x.shown_text, x.shown_speaker,
                  x.remaining_ms, x.shown_priority, x.queued_count, x.dropped_count);
         $display("%0t:   actual   acc %0d vis %0d id %0h txt %0h spk %0h rem %0d pri %0d q %0d drop %0d",
                  $time, got.accepted, got.visible, got.shown_id, got.shown_text,
                  got.shown_speaker, got.remaining_ms, got.shown_priority, got.queued_count,
                  got.dropped_count);
         errors++;
      end
   endfunction
endclass

module tb_preemptive_priority_cue_scheduler;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_op = '0;
   logic [15:0]        req_cue_id = '0;
   logic [31:0]        req_text_handle = '0;
   logic [31:0]        req_speaker_handle = '0;
   logic signed [15:0] req_priority_req = '0;
   logic [19:0]        req_duration_ms = '0;
   logic [19:0]        req_delta_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_accepted;
   logic               rsp_visible;
   logic [15:0]        rsp_shown_id;
   logic [31:0]        rsp_shown_text;
   logic [31:0]        rsp_shown_speaker;
   logic [18:0]        rsp_remaining_ms;
   logic signed [10:0] rsp_shown_priority;
   logic [4:0]         rsp_queued_count;
   logic [31:0]        rsp_dropped_count;

   cue_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;
   int  cue_pool = 8;

   preemptive_priority_cue_scheduler dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall)
            board.check_result('{rsp_accepted, rsp_visible, rsp_shown_id, rsp_shown_text,
                                 rsp_shown_speaker, rsp_remaining_ms, rsp_shown_priority,
                                 rsp_queued_count, rsp_dropped_count});
         if (quiet_cycles > 5000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);

   task automatic send(cue_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= r.op;
      req_cue_id <= r.cue_id;
      req_text_handle <= r.text;
      req_speaker_handle <= r.spk;
      req_priority_req <= r.prio;
      req_duration_ms <= r.dur;
      req_delta_ms <= r.delta;
      while (req_stall) @(negedge clock);
      @(posedge clock);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (board.pending.size() > 0);
   endtask

   function automatic cue_req_type mk(logic [1:0] op, int id, int p, int dur, int delta);
      cue_req_type r;
      r.op = op;
      r.cue_id = 16'(id);
      r.text = $urandom() | 1;
      r.spk = $urandom();
      r.prio = 16'(p);
      r.dur = 20'(dur);
      r.delta = 20'(delta);
      return r;
   endfunction

   function automatic cue_req_type rand_req();
      cue_req_type r;
      int k;
      k = $urandom_range(99);
      r = mk(ppcs_pkg::OP_ENQUEUE, $urandom_range(1, cue_pool), $urandom_range(0, 40) - 20,
             $urandom_range(1, 2000), $urandom_range(0, 1500));
      if ($urandom_range(9) == 0) r.prio = 16'($urandom());
      if ($urandom_range(19) == 0) r.dur = 20'($urandom_range(0, 1048575));
      if ($urandom_range(19) == 0) r.dur = 20'($urandom_range(1, 300000));
      if ($urandom_range(29) == 0) r.cue_id = 16'($urandom());
      if ($urandom_range(29) == 0) r.text = 0;
      else if ($urandom_range(9) == 0) r.text = $urandom();
      if ($urandom_range(9) == 0) r.delta = 20'($urandom());
      if (k < 62) r.op = ppcs_pkg::OP_ENQUEUE;
      else if (k < 95) r.op = ppcs_pkg::OP_TICK;
      else if (k < 98) r.op = ppcs_pkg::OP_CLEAR;
      else r.op = ppcs_pkg::OP_RESERVED;
      return r;
   endfunction

   initial begin
      cue_req_type r;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      send(mk(ppcs_pkg::OP_TICK, 1, 0, 1, 100));
      send(mk(ppcs_pkg::OP_ENQUEUE, 0, 5, 100, 0));
      r = mk(ppcs_pkg::OP_ENQUEUE, 1, 5, 100, 0);
      r.text = 0;
      send(r);
      send(mk(ppcs_pkg::OP_ENQUEUE, 1, 5, 0, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 1, 5, 300001, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 1, 5, 20'hFFFFF, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 16'hFFFF, 16'sh7FFF, 300000, 0));
      r = mk(ppcs_pkg::OP_ENQUEUE, 2, 16'sh8000, 1, 0);
      r.text = 32'hFFFF_FFFF;
      r.spk = 32'hFFFF_FFFF;
      send(r);
      send(mk(ppcs_pkg::OP_ENQUEUE, 3, 1000, 50, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 16'hFFFF, 10, 200, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 4, 10, 60, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 5, 11, 70, 0));
      send(mk(ppcs_pkg::OP_ENQUEUE, 2, 999, 80, 0));
      send(mk(ppcs_pkg::OP_TICK, 0, 0, 0, 0));
      send(mk(ppcs_pkg::OP_TICK, 0, 0, 0, 120));
      send(mk(ppcs_pkg::OP_ENQUEUE, 2, 16'shFC18, 90, 0));
      send(mk(ppcs_pkg::OP_TICK, 0, 0, 0, 20'hFFFFF));
      send(mk(ppcs_pkg::OP_ENQUEUE, 6, 3, 40, 0));
      send(mk(ppcs_pkg::OP_RESERVED, 6, 3, 40, 0));
      send(mk(ppcs_pkg::OP_CLEAR, 0, 0, 0, 0));
      drain();
      // fill the queue past its depth, holding off results for the first part of the run
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         for (int i = 1; i <= 20; i++) send(mk(ppcs_pkg::OP_ENQUEUE, 100 + i, 0, 500, 0));
      join
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 46 : 26) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 46 : 26) : 0;
         cue_pool = (ph % 2) ? 30 : 10;
         for (int n = 0; n < 345; n++) send(rand_req());
         drain();
      end
      repeat (200) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
